// ===== hw/rtl/key_matrix_debouncer_core_assert.svh =====
// Assertion macros used by the checker file of the key matrix debouncer.
`ifndef KEY_MATRIX_DEBOUNCER_CORE_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define KMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key matrix debouncer check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define KMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key matrix debouncer check failed");

`endif

// ===== hw/rtl/kmd_pkg.sv =====
`timescale 1ns / 1ps

package kmd_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 7;
  localparam int ROW_W = 3;
  localparam int COL_W = 3;
  localparam int CNT_W = 8;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Debounce states of one key.
  localparam logic [1:0] ST_RELEASED  = 2'd0;
  localparam logic [1:0] ST_ARMING    = 2'd1;
  localparam logic [1:0] ST_PRESSED   = 2'd2;
  localparam logic [1:0] ST_DISARMING = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_BASE_NOTE = 1'b1;

  localparam logic [7:0] THRESHOLD_RESET = 8'd10;
  localparam logic [6:0] BASE_NOTE_RESET = 7'd24;
  localparam logic [6:0] ODD_NOTE = 7'd99;

  // One scanned row that produced at least one confirmed change.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COLS-1:0]  ev_mask;
    logic [COLS-1:0]  dir_mask;
  } evt_t;

  function automatic logic [6:0] note_of(input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col,
                                         input logic [6:0] base);
    int sum;
    sum = int'(base) + 8 * (COLS - 1 - int'(col)) + (ROWS - 1 - int'(row));
    if (col == '0 && int'(row) != ROWS - 1) begin
      return ODD_NOTE;
    end
    return sum[6:0];
  endfunction

endpackage

// ===== hw/rtl/kmd_front.sv =====
`timescale 1ns / 1ps

module kmd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [kmd_pkg::ROW_W-1:0]  row,
  input  logic [kmd_pkg::COLS-1:0]   pressed_bits,
  input  logic [7:0]                 threshold,
  input  logic                       q_full,
  output logic                       push,
  output kmd_pkg::evt_t              push_item
);

  logic [2*kmd_pkg::COLS-1:0]              st_row   [kmd_pkg::ROWS];
  logic [kmd_pkg::CNT_W*kmd_pkg::COLS-1:0] cnt_row  [kmd_pkg::ROWS];
  logic [2*kmd_pkg::COLS-1:0]              st_next;
  logic [kmd_pkg::CNT_W*kmd_pkg::COLS-1:0] cnt_next;
  logic [kmd_pkg::COLS-1:0]                ev_mask;
  logic [kmd_pkg::COLS-1:0]                dir_mask;
  logic                                    accept;
  logic                                    row_ok;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign row_ok   = int'(row) < kmd_pkg::ROWS;

  // Every key of the scanned row steps its debounce machine in parallel.
  always_comb begin
    logic [1:0]               st;
    logic [kmd_pkg::CNT_W-1:0] cnt;
    logic [kmd_pkg::CNT_W-1:0] cnt_inc;
    st_next  = st_row[row];
    cnt_next = cnt_row[row];
    ev_mask  = '0;
    dir_mask = '0;
    for (int c = 0; c < kmd_pkg::COLS; c++) begin
      st      = st_row[row][2*c +: 2];
      cnt     = cnt_row[row][kmd_pkg::CNT_W*c +: kmd_pkg::CNT_W];
      cnt_inc = (cnt == '1) ? cnt : cnt + 1'b1;
      if (pressed_bits[c]) begin
        unique case (st)
          kmd_pkg::ST_RELEASED: begin
            st_next[2*c +: 2] = kmd_pkg::ST_ARMING;
            cnt_next[kmd_pkg::CNT_W*c +: kmd_pkg::CNT_W] = '0;
          end
          kmd_pkg::ST_ARMING: begin
            cnt_next[kmd_pkg::CNT_W*c +: kmd_pkg::CNT_W] = cnt_inc;
            if (cnt_inc > threshold) begin
              st_next[2*c +: 2] = kmd_pkg::ST_PRESSED;
              ev_mask[c]  = 1'b1;
              dir_mask[c] = 1'b1;
            end
          end
          kmd_pkg::ST_PRESSED, kmd_pkg::ST_DISARMING: begin
            st_next[2*c +: 2] = kmd_pkg::ST_PRESSED;
          end
          default: begin
            st_next[2*c +: 2] = st;
          end
        endcase
      end else begin
        unique case (st)
          kmd_pkg::ST_PRESSED: begin
            st_next[2*c +: 2] = kmd_pkg::ST_DISARMING;
            cnt_next[kmd_pkg::CNT_W*c +: kmd_pkg::CNT_W] = '0;
          end
          kmd_pkg::ST_DISARMING: begin
            cnt_next[kmd_pkg::CNT_W*c +: kmd_pkg::CNT_W] = cnt_inc;
            if (cnt_inc > threshold) begin
              st_next[2*c +: 2] = kmd_pkg::ST_RELEASED;
              ev_mask[c] = 1'b1;
            end
          end
          kmd_pkg::ST_RELEASED, kmd_pkg::ST_ARMING: begin
            st_next[2*c +: 2] = kmd_pkg::ST_RELEASED;
          end
          default: begin
            st_next[2*c +: 2] = st;
          end
        endcase
      end
    end
  end

  assign push               = accept && row_ok && (ev_mask != '0);
  assign push_item.row      = row;
  assign push_item.ev_mask  = ev_mask;
  assign push_item.dir_mask = dir_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < kmd_pkg::ROWS; r++) begin
        st_row[r]  <= {kmd_pkg::COLS{kmd_pkg::ST_RELEASED}};
        cnt_row[r] <= '0;
      end
    end else if (accept && row_ok) begin
      st_row[row]  <= st_next;
      cnt_row[row] <= cnt_next;
    end
  end

endmodule

// ===== hw/rtl/kmd_queue.sv =====
`timescale 1ns / 1ps

module kmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kmd_pkg::evt_t push_item,
  output logic          full,
  input  logic          pop,
  output kmd_pkg::evt_t pop_item,
  output logic          empty
);

  kmd_pkg::evt_t                 entries [kmd_pkg::QDEPTH];
  logic [kmd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [kmd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [kmd_pkg::QCNT_W-1:0]    fill;
  logic                          do_push;
  logic                          do_pop;

  assign full     = fill == kmd_pkg::QCNT_W'(kmd_pkg::QDEPTH);
  assign empty    = fill == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/kmd_back.sv =====
`timescale 1ns / 1ps

module kmd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  kmd_pkg::evt_t        q_item,
  output logic                 pop,
  input  logic [6:0]           base_note,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [6:0]           note,
  output logic                 pressed,
  output logic                 last
);

  logic                        cur_valid;
  logic [kmd_pkg::ROW_W-1:0]   cur_row;
  logic [kmd_pkg::COLS-1:0]    cur_mask;
  logic [kmd_pkg::COLS-1:0]    cur_dir;
  logic [kmd_pkg::COLS-1:0]    mask_next;
  logic [kmd_pkg::COL_W-1:0]   col;
  logic                        out_load;
  logic                        cur_done;

  // Lowest pending column goes out first.
  always_comb begin
    logic found;
    found = 1'b0;
    col   = '0;
    for (int c = 0; c < kmd_pkg::COLS; c++) begin
      if (cur_mask[c] && !found) begin
        found = 1'b1;
        col   = kmd_pkg::COL_W'(c);
      end
    end
    mask_next      = cur_mask;
    mask_next[col] = 1'b0;
  end

  assign out_load = cur_valid && (!m_tvalid || m_tready);
  assign cur_done = out_load && (mask_next == '0);
  assign pop      = !q_empty && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (cur_done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_row  <= q_item.row;
      cur_mask <= q_item.ev_mask;
      cur_dir  <= q_item.dir_mask;
    end else if (out_load) begin
      cur_mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      note    <= kmd_pkg::note_of(cur_row, col, base_note);
      pressed <= cur_dir[col];
      last    <= mask_next == '0;
    end
  end

endmodule

// ===== hw/rtl/key_matrix_debouncer_core.sv =====
`timescale 1ns / 1ps
// Key matrix debouncer.
// Input stream: one transfer per scanned row, s_tdata holds the row index and the
// mask of column lines that read pressed. Every key runs a debounce machine; a
// level change is confirmed once it has held for more than the threshold
// further scans. Output stream: one transfer per confirmed change, carrying the
// key's note number and direction, in ascending column order, with m_tlast on
// the final change caused by that row. Rows with no change produce nothing.
// Throughput: a row is accepted every cycle while the four-entry event queue has
// room; the output side drains one event per cycle while the receiver accepts
// them. A row's event passes the queue, the current-row registers and the output
// registers before it reaches m_tdata.
// Configuration: cfg_we writes register cfg_index (0 threshold, 1 base note)
// from cfg_data; write only while the block is idle.
// Reset puts every key in the released state with a zero count and restores
// threshold 10 and base note 24. When the receiver stalls, the held event stays
// on m_tdata, the queue fills, and s_tready falls once it is full.

module key_matrix_debouncer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [2:0] row, [9:3] pressed_bits, [15:10] zero
  input  logic [kmd_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [6:0] note, [7] pressed
  output logic [kmd_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [7:0]                    cfg_data
);

  logic [7:0]     threshold;
  logic [6:0]     base_note;
  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  kmd_pkg::evt_t  push_item;
  kmd_pkg::evt_t  pop_item;
  logic [6:0]     note;
  logic           pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= kmd_pkg::THRESHOLD_RESET;
      base_note <= kmd_pkg::BASE_NOTE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmd_pkg::CFG_THRESHOLD: threshold <= cfg_data;
        kmd_pkg::CFG_BASE_NOTE: base_note <= cfg_data[6:0];
        default:                threshold <= threshold;
      endcase
    end
  end

  kmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .row          (s_tdata[2:0]),
    .pressed_bits (s_tdata[9:3]),
    .threshold    (threshold),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  kmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  kmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .base_note (base_note),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .note      (note),
    .pressed   (pressed),
    .last      (m_tlast)
  );

  assign m_tdata = {pressed, note};

endmodule

// ===== hw/rtl/kmd_checker.sv =====
`timescale 1ns / 1ps
`include "key_matrix_debouncer_core_assert.svh"

module kmd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [kmd_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);

  // A stalled event holds its payload.
  `KMD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Events of one row leave back to back once the receiver takes them.
  `KMD_ASSERT_NEXT(a_row_burst, m_tvalid && m_tready && !m_tlast, m_tvalid)

  // The input only stalls when queued events are waiting at the output.
  `KMD_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid)

  // Nothing comes out right after reset.
  `KMD_ASSERT_NOW(a_reset_quiet, $past(rst), !m_tvalid)

endmodule

bind key_matrix_debouncer_core kmd_checker u_kmd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
